>>> rtl/hsv_pkg.sv
package hsv_pkg;

    localparam int HUE_W   = 17;
    localparam int SV_W    = 10;
    localparam int UNIT_W  = 9;
    localparam int HUE_IX_W = 15;
    localparam int REM_W   = 12;
    localparam int TERM_W  = 20;
    localparam int PROD_W  = 29;
    localparam int NUM_SECTORS = 6;

    // 360 degrees with 6 fraction bits, one sector span, 1.0 and 1.0 x span
    localparam logic signed [HUE_W:0] HUE_FULL = 18'sd23040;
    localparam int                    SPAN     = 3840;
    localparam logic [REM_W-1:0]      REM_SPAN = 12'd3840;
    localparam logic [UNIT_W-1:0]     UNIT     = 9'd256;
    localparam logic [TERM_W-1:0]     W_FULL   = 20'd983040;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    // wrapped hue, clamped saturation and value
    typedef struct packed {
        logic                black;
        logic [HUE_IX_W-1:0] hue;
        logic [UNIT_W-1:0]   sat;
        logic [UNIT_W-1:0]   val;
    } t_s1;

    // sector and remainder within it
    typedef struct packed {
        logic              black;
        t_sector           sector;
        logic [REM_W-1:0]  rem;
        logic [UNIT_W-1:0] sat;
        logic [UNIT_W-1:0] val;
    } t_s2;

    // weights of the p, q and t terms
    typedef struct packed {
        logic              black;
        t_sector           sector;
        logic [UNIT_W-1:0] val;
        logic [TERM_W-1:0] w_p;
        logic [TERM_W-1:0] w_q;
        logic [TERM_W-1:0] w_t;
    } t_s3;

    // value times weight
    typedef struct packed {
        logic              black;
        t_sector           sector;
        logic [UNIT_W-1:0] val;
        logic [PROD_W-1:0] vw_p;
        logic [PROD_W-1:0] vw_q;
        logic [PROD_W-1:0] vw_t;
    } t_s4;

    typedef struct packed {
        logic [15:0] rgb565;
        logic [7:0]  red8;
        logic [7:0]  green8;
        logic [7:0]  blue8;
    } t_rgb;

    function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [SV_W-1:0] x);
        logic [UNIT_W-1:0] res;
        if (x < 0) begin
            res = '0;
        end else if (x > $signed(10'sd256)) begin
            res = UNIT;
        end else begin
            res = x[UNIT_W-1:0];
        end
        return res;
    endfunction

    // floor(255 * v * W / (2^16 * 3840)) == floor(17 * v * W / 2^24)
    function automatic logic [7:0] chan8(input logic [PROD_W-1:0] vw);
        logic [33:0] p;
        p = {1'b0, vw, 4'b0} + {5'b0, vw};
        return p[31:24];
    endfunction

endpackage

>>> rtl/hsv_req_if.sv
interface hsv_req_if;
    logic              valid;
    logic              ready;
    logic signed [16:0] hue_q6;
    logic signed [9:0]  sat_q8;
    logic signed [9:0]  val_q8;

    modport source (output valid, output hue_q6, output sat_q8, output val_q8, input ready);
    modport sink   (input valid, input hue_q6, input sat_q8, input val_q8, output ready);
endinterface

>>> rtl/hsv_rsp_if.sv
interface hsv_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] rgb565;
    logic [7:0]  red8;
    logic [7:0]  green8;
    logic [7:0]  blue8;

    modport source (output valid, output rgb565, output red8, output green8, output blue8,
                    input ready);
    modport sink   (input valid, input rgb565, input red8, input green8, input blue8,
                    output ready);
endinterface

>>> rtl/hsv_hue.sv
module hsv_hue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    output logic               o_rdy,
    input  logic signed [16:0] i_hue,
    input  logic signed [9:0]  i_sat,
    input  logic signed [9:0]  i_val,
    output logic               o_vld,
    input  logic               i_rdy,
    output hsv_pkg::t_s2       o_data
);
    import hsv_pkg::*;

    logic r_vld1, r_vld2;
    t_s1  r_d1, n_d1;
    t_s2  r_d2, n_d2;
    logic rdy1, rdy2;

    assign rdy2  = !r_vld2 || i_rdy;
    assign rdy1  = !r_vld1 || rdy2;
    assign o_rdy = rdy1;
    assign o_vld = r_vld2;
    assign o_data = r_d2;

    // wrap the hue once, fold 360 onto 0, clamp saturation and value
    always_comb begin
        logic signed [HUE_W:0] h_ext;
        logic signed [HUE_W:0] h_wrap;
        h_ext = {i_hue[HUE_W-1], i_hue};
        if (h_ext > HUE_FULL) begin
            h_wrap = h_ext - HUE_FULL;
        end else if (h_ext < 0) begin
            h_wrap = h_ext + HUE_FULL;
        end else begin
            h_wrap = h_ext;
        end
        if (h_wrap == HUE_FULL) begin
            h_wrap = '0;
        end
        n_d1.black = (h_wrap < 0) || (h_wrap >= HUE_FULL);
        n_d1.hue   = h_wrap[HUE_IX_W-1:0];
        n_d1.sat   = clamp_unit(i_sat);
        n_d1.val   = clamp_unit(i_val);
    end

    // sector by comparison against the sector bounds
    always_comb begin
        logic [HUE_IX_W-1:0] base;
        t_sector             sec;
        base = '0;
        sec  = SEC_RED_YEL;
        for (int k = 1; k < NUM_SECTORS; k++) begin
            if (r_d1.hue >= HUE_IX_W'(k * SPAN)) begin
                base = HUE_IX_W'(k * SPAN);
                sec  = t_sector'(3'(k));
            end
        end
        n_d2.black  = r_d1.black;
        n_d2.sector = sec;
        n_d2.rem    = REM_W'(r_d1.hue - base);
        n_d2.sat    = r_d1.sat;
        n_d2.val    = r_d1.val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_vld1 <= i_vld;
            end
            if (rdy2) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_vld) begin
            r_d1 <= n_d1;
        end
        if (rdy2 && r_vld1) begin
            r_d2 <= n_d2;
        end
    end

`ifndef SYNTHESIS
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld1 |-> (r_d1.black || r_d1.hue < HUE_IX_W'(HUE_FULL)))
        else $error("wrapped hue out of range");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld2 && !r_d2.black) |-> (r_d2.rem < REM_SPAN && r_d2.sector <= SEC_MAG_RED))
        else $error("sector remainder out of range");
`endif

endmodule

>>> rtl/hsv_term.sv
module hsv_term (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_vld,
    output logic         o_rdy,
    input  hsv_pkg::t_s2 i_data,
    output logic         o_vld,
    input  logic         i_rdy,
    output hsv_pkg::t_s4 o_data
);
    import hsv_pkg::*;

    logic r_vld3, r_vld4;
    t_s3  r_d3, n_d3;
    t_s4  r_d4, n_d4;
    logic rdy3, rdy4;

    assign rdy4   = !r_vld4 || i_rdy;
    assign rdy3   = !r_vld3 || rdy4;
    assign o_rdy  = rdy3;
    assign o_vld  = r_vld4;
    assign o_data = r_d4;

    // weights: 1.0 * span less saturation times span, rem or span - rem
    always_comb begin
        logic [TERM_W:0] sp, sq, st;
        sp = (TERM_W+1)'(i_data.sat) * (TERM_W+1)'(REM_SPAN);
        sq = (TERM_W+1)'(i_data.sat) * (TERM_W+1)'(i_data.rem);
        st = (TERM_W+1)'(i_data.sat) * (TERM_W+1)'(REM_SPAN - i_data.rem);
        n_d3.black  = i_data.black;
        n_d3.sector = i_data.sector;
        n_d3.val    = i_data.val;
        n_d3.w_p    = W_FULL - sp[TERM_W-1:0];
        n_d3.w_q    = W_FULL - sq[TERM_W-1:0];
        n_d3.w_t    = W_FULL - st[TERM_W-1:0];
    end

    always_comb begin
        n_d4.black  = r_d3.black;
        n_d4.sector = r_d3.sector;
        n_d4.val    = r_d3.val;
        n_d4.vw_p   = PROD_W'(r_d3.val) * PROD_W'(r_d3.w_p);
        n_d4.vw_q   = PROD_W'(r_d3.val) * PROD_W'(r_d3.w_q);
        n_d4.vw_t   = PROD_W'(r_d3.val) * PROD_W'(r_d3.w_t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (rdy3) begin
                r_vld3 <= i_vld;
            end
            if (rdy4) begin
                r_vld4 <= r_vld3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3 && i_vld) begin
            r_d3 <= n_d3;
        end
        if (rdy4 && r_vld3) begin
            r_d4 <= n_d4;
        end
    end

`ifndef SYNTHESIS
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld3 && !r_d3.black) |->
            (r_d3.w_p <= W_FULL && r_d3.w_q <= W_FULL && r_d3.w_t <= W_FULL))
        else $error("term weight wrapped");
`endif

endmodule

>>> rtl/hsv_chan.sv
module hsv_chan (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    output logic          o_rdy,
    input  hsv_pkg::t_s4  i_data,
    output logic          o_vld,
    input  logic          i_rdy,
    output hsv_pkg::t_rgb o_data
);
    import hsv_pkg::*;

    logic r_vld;
    t_rgb r_out, n_out;
    logic rdy;

    assign rdy    = !r_vld || i_rdy;
    assign o_rdy  = rdy;
    assign o_vld  = r_vld;
    assign o_data = r_out;

    // scale each term to 8 bits, route by sector, pack 5/6/5
    always_comb begin
        logic [16:0] vv;
        logic [7:0]  cv, cp, cq, ct;
        logic [7:0]  r, g, b;
        vv = {i_data.val, 8'b0} - 17'(i_data.val);
        cv = vv[15:8];
        cp = chan8(i_data.vw_p);
        cq = chan8(i_data.vw_q);
        ct = chan8(i_data.vw_t);
        unique case (i_data.sector)
            SEC_RED_YEL: begin r = cv; g = ct; b = cp; end
            SEC_YEL_GRN: begin r = cq; g = cv; b = cp; end
            SEC_GRN_CYN: begin r = cp; g = cv; b = ct; end
            SEC_CYN_BLU: begin r = cp; g = cq; b = cv; end
            SEC_BLU_MAG: begin r = ct; g = cp; b = cv; end
            default:     begin r = cv; g = cp; b = cq; end
        endcase
        if (i_data.black) begin
            r = '0;
            g = '0;
            b = '0;
        end
        n_out.red8   = r;
        n_out.green8 = g;
        n_out.blue8  = b;
        n_out.rgb565 = {r[7:3], g[7:2], b[7:3]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy && i_vld) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !i_rdy) |=> (r_vld && $stable(r_out)))
        else $error("output lost during stall");
`endif

endmodule

>>> rtl/hsv_to_rgb565_unit.sv
// HSV to RGB565 colour converter.
// i_req (sink) carries one colour per request: hue_q6 in degrees x 64,
// sat_q8 and val_q8 with 256 as full scale. A hue above 360 degrees or
// below zero is wrapped once; exactly 360 reads as red; a hue still out of
// range gives black. Saturation and value are clamped to 0..256.
// o_rsp (source) returns one response per request: the 8-bit channels
// floor(255 x fraction) and the packed RGB565 word, in request order.
// Throughput is one request per cycle while the receiver accepts: a
// five-stage pipeline (hue wrap, sector split, term weights, value
// products, scale and pack), each stage with its own valid bit, so an item
// enters on every clock unless every stage is full and stalled.
// When the receiver stalls, the output register holds its response and each
// stage fills its bubble before refusing; i_req.ready drops only once every
// stage is full. Reset clears all valid bits and no response is pending.
module hsv_to_rgb565_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hsv_req_if.sink          i_req,
    hsv_rsp_if.source        o_rsp
);
    import hsv_pkg::*;

    // hue stages to term stages
    logic vld_a, rdy_a;
    t_s2  data_a;
    // term stages to channel stage
    logic vld_b, rdy_b;
    t_s4  data_b;
    t_rgb rgb;

    // wrap hue, clamp, split into sector and remainder
    hsv_hue u_hue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_req.valid),
        .o_rdy   (i_req.ready),
        .i_hue   (i_req.hue_q6),
        .i_sat   (i_req.sat_q8),
        .i_val   (i_req.val_q8),
        .o_vld   (vld_a),
        .i_rdy   (rdy_a),
        .o_data  (data_a)
    );

    // form p, q, t weights and multiply by value
    hsv_term u_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (vld_a),
        .o_rdy   (rdy_a),
        .i_data  (data_a),
        .o_vld   (vld_b),
        .i_rdy   (rdy_b),
        .o_data  (data_b)
    );

    // scale to 8 bits, route by sector, pack and hold for the receiver
    hsv_chan u_chan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (vld_b),
        .o_rdy   (rdy_b),
        .i_data  (data_b),
        .o_vld   (o_rsp.valid),
        .i_rdy   (o_rsp.ready),
        .o_data  (rgb)
    );

    assign o_rsp.rgb565 = rgb.rgb565;
    assign o_rsp.red8   = rgb.red8;
    assign o_rsp.green8 = rgb.green8;
    assign o_rsp.blue8  = rgb.blue8;

endmodule
